// ----- sv/m3qs_pkg.sv -----
// Shared types and constants for the median-of-three quicksort block.
// No dependencies; used by the controller, the datapath and the top level.
package m3qs_pkg;

  // Default sizing of the block
  localparam int DEF_MAX_ITEMS   = 1024;
  localparam int DEF_DATA_WIDTH  = 32;
  localparam int DEF_STACK_DEPTH = 11;

  // Fixed port widths
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 11;
  localparam int INDEX_W  = 10;
  localparam int STATUS_W = 2;

  // Item commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_READ_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SORT_DONE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  // Datapath operations issued by the controller, one per cycle
  typedef enum logic [4:0] {
    OP_IDLE,
    OP_NOP,
    OP_RD_OUT,
    OP_POP,
    OP_FINISH,
    OP_RD_LO,
    OP_RD_MID,
    OP_RD_HI,
    OP_CAP_HI,
    OP_SW_AM,
    OP_SW_AH,
    OP_SW_MH,
    OP_WR_LO,
    OP_WR_HI,
    OP_WR_MID,
    OP_P_RD,
    OP_P_CMP,
    OP_P_SW1,
    OP_P_SW2,
    OP_F_RD,
    OP_F_W1,
    OP_F_W2,
    OP_DEC,
    OP_I_RDK,
    OP_I_CAPX,
    OP_I_RDM,
    OP_I_CMP,
    OP_I_WR
  } op_t;

  // Datapath status seen by the controller
  typedef struct packed {
    logic start_sort;
    logic start_read;
    logic lo_lt_hi;
    logic sp_zero;
    logic j_eq_hi;
    logic rd_lt_pv;
    logic i_eq_j;
    logic need_ins;
    logic i_gt_ilo;
    logic rd_gt_x;
    logic j_eq_ihi;
  } stat_t;

endpackage

// ----- sv/median_of_three_quicksort.sv -----
// Median-of-three quicksort block. A load is written straight into the
// element store in the cycle it is taken; a read goes out through the
// store's registered read port and a read-out step, and an out-of-range
// read or a load into a full store has its result loaded in the cycle it
// is taken. The load marked last starts an in-place ascending sort that
// holds the input stalled until the sort-done result is issued: each range
// goes through the median-of-three setup (with a pop first when it comes
// off the stack), a scan that reads and compares each element and swaps
// those below the pivot, and the steps that place the pivot and pick the
// next range, all bound by the single store read port. Pending ranges sit
// on a small stack of STACK_DEPTH entries; if it fills, the smaller side is
// finished by an insertion sort.
// No clearing pass is needed after reset. Results leave through an output
// register, so a new item is taken in the cycle a pending result transfers.
// Depends on m3qs_pkg, m3qs_ctrl, m3qs_dp and m3qs_ram.
module median_of_three_quicksort #(
  parameter int MAX_ITEMS   = m3qs_pkg::DEF_MAX_ITEMS,
  parameter int DATA_WIDTH  = m3qs_pkg::DEF_DATA_WIDTH,
  parameter int STACK_DEPTH = m3qs_pkg::DEF_STACK_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_command,
  input  logic signed [m3qs_pkg::VALUE_W-1:0]  in_value,
  input  logic                                 in_last,
  input  logic [m3qs_pkg::INDEX_W-1:0]         in_read_index,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [m3qs_pkg::VALUE_W-1:0]  out_sorted_value,
  output logic [m3qs_pkg::COUNT_W-1:0]         out_element_count,
  output logic [m3qs_pkg::STATUS_W-1:0]        out_status
);

  m3qs_pkg::op_t   op;
  m3qs_pkg::stat_t stat;

  m3qs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .op    (op)
  );

  m3qs_dp #(
    .MAX_ITEMS   (MAX_ITEMS),
    .DATA_WIDTH  (DATA_WIDTH),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .op                (op),
    .stat              (stat),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_value          (in_value),
    .in_last           (in_last),
    .in_read_index     (in_read_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sorted_value  (out_sorted_value),
    .out_element_count (out_element_count),
    .out_status        (out_status)
  );

endmodule

// ----- sv/m3qs_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module m3qs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/m3qs_ctrl.sv -----
// Sequencer for the median-of-three quicksort block.
// Depends on m3qs_pkg for the operation codes and the status struct.
module m3qs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  m3qs_pkg::stat_t stat,
  output m3qs_pkg::op_t   op
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_RD_OUT,
    S_TOP,
    S_RD_LO,
    S_RD_MID,
    S_RD_HI,
    S_CAP_HI,
    S_SW_AM,
    S_SW_AH,
    S_SW_MH,
    S_WR_LO,
    S_WR_HI,
    S_WR_MID,
    S_P_RD,
    S_P_CMP,
    S_P_SW1,
    S_P_SW2,
    S_F_W1,
    S_F_W2,
    S_DEC,
    S_I_RDK,
    S_I_CAPX,
    S_I_CHK,
    S_I_CMP,
    S_I_WR,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    op        = m3qs_pkg::OP_NOP;
    case (state_r)
      S_IDLE: begin
        op = m3qs_pkg::OP_IDLE;
        if (stat.start_sort) begin
          state_nxt = S_TOP;
        end else if (stat.start_read) begin
          state_nxt = S_RD_OUT;
        end
      end
      S_RD_OUT: begin
        op        = m3qs_pkg::OP_RD_OUT;
        state_nxt = S_IDLE;
      end
      S_TOP: begin
        if (stat.lo_lt_hi) begin
          state_nxt = S_RD_LO;
        end else if (stat.sp_zero) begin
          state_nxt = S_FINISH;
        end else begin
          op = m3qs_pkg::OP_POP;
        end
      end
      S_RD_LO: begin
        op        = m3qs_pkg::OP_RD_LO;
        state_nxt = S_RD_MID;
      end
      S_RD_MID: begin
        op        = m3qs_pkg::OP_RD_MID;
        state_nxt = S_RD_HI;
      end
      S_RD_HI: begin
        op        = m3qs_pkg::OP_RD_HI;
        state_nxt = S_CAP_HI;
      end
      S_CAP_HI: begin
        op        = m3qs_pkg::OP_CAP_HI;
        state_nxt = S_SW_AM;
      end
      S_SW_AM: begin
        op        = m3qs_pkg::OP_SW_AM;
        state_nxt = S_SW_AH;
      end
      S_SW_AH: begin
        op        = m3qs_pkg::OP_SW_AH;
        state_nxt = S_SW_MH;
      end
      S_SW_MH: begin
        op        = m3qs_pkg::OP_SW_MH;
        state_nxt = S_WR_LO;
      end
      S_WR_LO: begin
        op        = m3qs_pkg::OP_WR_LO;
        state_nxt = S_WR_HI;
      end
      S_WR_HI: begin
        op        = m3qs_pkg::OP_WR_HI;
        state_nxt = S_WR_MID;
      end
      S_WR_MID: begin
        op        = m3qs_pkg::OP_WR_MID;
        state_nxt = S_P_RD;
      end
      S_P_RD: begin
        // scan done: fetch the slot the pivot lands in
        if (stat.j_eq_hi) begin
          op        = m3qs_pkg::OP_F_RD;
          state_nxt = S_F_W1;
        end else begin
          op        = m3qs_pkg::OP_P_RD;
          state_nxt = S_P_CMP;
        end
      end
      S_P_CMP: begin
        op = m3qs_pkg::OP_P_CMP;
        if (stat.rd_lt_pv && !stat.i_eq_j) begin
          state_nxt = S_P_SW1;
        end else begin
          state_nxt = S_P_RD;
        end
      end
      S_P_SW1: begin
        op        = m3qs_pkg::OP_P_SW1;
        state_nxt = S_P_SW2;
      end
      S_P_SW2: begin
        op        = m3qs_pkg::OP_P_SW2;
        state_nxt = S_P_RD;
      end
      S_F_W1: begin
        op        = m3qs_pkg::OP_F_W1;
        state_nxt = S_F_W2;
      end
      S_F_W2: begin
        op        = m3qs_pkg::OP_F_W2;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        op        = m3qs_pkg::OP_DEC;
        state_nxt = stat.need_ins ? S_I_RDK : S_TOP;
      end
      S_I_RDK: begin
        op        = m3qs_pkg::OP_I_RDK;
        state_nxt = S_I_CAPX;
      end
      S_I_CAPX: begin
        op        = m3qs_pkg::OP_I_CAPX;
        state_nxt = S_I_CHK;
      end
      S_I_CHK: begin
        if (stat.i_gt_ilo) begin
          op        = m3qs_pkg::OP_I_RDM;
          state_nxt = S_I_CMP;
        end else begin
          state_nxt = S_I_WR;
        end
      end
      S_I_CMP: begin
        op        = m3qs_pkg::OP_I_CMP;
        state_nxt = stat.rd_gt_x ? S_I_CHK : S_I_WR;
      end
      S_I_WR: begin
        op        = m3qs_pkg::OP_I_WR;
        state_nxt = stat.j_eq_ihi ? S_TOP : S_I_RDK;
      end
      S_FINISH: begin
        op        = m3qs_pkg::OP_FINISH;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- sv/m3qs_dp.sv -----
// Datapath of the median-of-three quicksort block: element store, range
// registers, range stack, compare logic and result register.
// Depends on m3qs_pkg and m3qs_ram.
module m3qs_dp #(
  parameter int MAX_ITEMS   = m3qs_pkg::DEF_MAX_ITEMS,
  parameter int DATA_WIDTH  = m3qs_pkg::DEF_DATA_WIDTH,
  parameter int STACK_DEPTH = m3qs_pkg::DEF_STACK_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  m3qs_pkg::op_t                        op,
  output m3qs_pkg::stat_t                      stat,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_command,
  input  logic signed [m3qs_pkg::VALUE_W-1:0]  in_value,
  input  logic                                 in_last,
  input  logic [m3qs_pkg::INDEX_W-1:0]         in_read_index,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [m3qs_pkg::VALUE_W-1:0]  out_sorted_value,
  output logic [m3qs_pkg::COUNT_W-1:0]         out_element_count,
  output logic [m3qs_pkg::STATUS_W-1:0]        out_status
);

  localparam int ADDR_W = $clog2(MAX_ITEMS);
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int SP_W   = $clog2(STACK_DEPTH + 1);
  localparam int SI_W   = $clog2(STACK_DEPTH);
  localparam int CMP_W  = (CNT_W > m3qs_pkg::INDEX_W) ? CNT_W : m3qs_pkg::INDEX_W;

  typedef logic [ADDR_W-1:0] addr_t;

  addr_t                  lo_r, hi_r, i_r, j_r, ilo_r, ihi_r;
  logic signed [DATA_WIDTH-1:0] va_r, vm_r, vh_r;
  logic [CNT_W-1:0]       fill_r;
  logic                   sorted_r;
  logic [SP_W-1:0]        sp_r;
  logic [2*ADDR_W-1:0]    stk_r [STACK_DEPTH];

  logic                   out_valid_r;
  logic signed [m3qs_pkg::VALUE_W-1:0] out_value_r, out_value_nxt;
  logic [m3qs_pkg::COUNT_W-1:0]  out_count_r, out_count_nxt;
  logic [m3qs_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                   out_load;

  logic                   ram_we;
  addr_t                  ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0]  ram_wdata, ram_q;
  logic signed [DATA_WIDTH-1:0] rdata, ld_val;

  logic                   accept, do_load, is_full, rd_ok;
  logic [CNT_W-1:0]       fill_eff;
  addr_t                  span, mid;
  logic                   alias_m;
  addr_t                  left_sz, right_sz, p_m1, p_p1;
  logic                   left_small, s_empty, b_empty, b_triv, sp_full;
  addr_t                  s_lo, s_hi, b_lo, b_hi;
  logic [SP_W-1:0]        sp_m1;
  logic [2*ADDR_W-1:0]    pop_ent;

  m3qs_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  assign rdata  = $signed(ram_q);
  // Input values are taken as DATA_WIDTH-bit words: truncate or zero-extend
  assign ld_val = DATA_WIDTH'($unsigned(in_value));

  // Input handshake and item decode
  assign in_stall = (op != m3qs_pkg::OP_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign fill_eff = sorted_r ? '0 : fill_r;
  assign is_full  = (fill_eff == CNT_W'(MAX_ITEMS));
  assign do_load  = accept && (in_command == m3qs_pkg::CMD_LOAD);
  assign rd_ok    = CMP_W'(in_read_index) < CMP_W'(fill_r);

  // Median-of-three position; mid aliases lo on a two-entry range
  assign span    = hi_r - lo_r;
  assign mid     = lo_r + (span >> 1);
  assign alias_m = (mid == lo_r);

  // Split decision around the pivot position i_r
  assign left_sz    = i_r - lo_r;
  assign right_sz   = hi_r - i_r;
  assign left_small = (left_sz <= right_sz);
  assign p_m1       = i_r - 1'b1;
  assign p_p1       = i_r + 1'b1;
  assign s_empty    = left_small ? (i_r == lo_r) : (i_r == hi_r);
  assign s_lo       = left_small ? lo_r : p_p1;
  assign s_hi       = left_small ? p_m1 : hi_r;
  assign b_empty    = left_small ? (i_r == hi_r) : (i_r == lo_r);
  assign b_lo       = left_small ? p_p1 : lo_r;
  assign b_hi       = left_small ? hi_r : p_m1;
  assign b_triv     = b_empty || (b_lo >= b_hi);
  assign sp_full    = (sp_r == SP_W'(STACK_DEPTH));
  assign sp_m1      = sp_r - 1'b1;
  assign pop_ent    = stk_r[sp_m1[SI_W-1:0]];

  always_comb begin
    stat.start_sort = do_load && !is_full && in_last;
    stat.start_read = accept && (in_command == m3qs_pkg::CMD_READ) && rd_ok;
    stat.lo_lt_hi   = (lo_r < hi_r);
    stat.sp_zero    = (sp_r == '0);
    stat.j_eq_hi    = (j_r == hi_r);
    stat.rd_lt_pv   = (rdata < vm_r);
    stat.i_eq_j     = (i_r == j_r);
    stat.need_ins   = !b_triv && sp_full && !s_empty && (s_lo < s_hi);
    stat.i_gt_ilo   = (i_r > ilo_r);
    stat.rd_gt_x    = (rdata > va_r);
    stat.j_eq_ihi   = (j_r == ihi_r);
  end

  // Store port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    case (op)
      m3qs_pkg::OP_IDLE: begin
        ram_raddr = ADDR_W'(in_read_index);
        ram_we    = do_load && !is_full;
        ram_waddr = fill_eff[ADDR_W-1:0];
        ram_wdata = ld_val;
      end
      m3qs_pkg::OP_RD_LO:  ram_raddr = lo_r;
      m3qs_pkg::OP_RD_MID: ram_raddr = mid;
      m3qs_pkg::OP_RD_HI:  ram_raddr = hi_r;
      m3qs_pkg::OP_WR_LO: begin
        ram_we = 1'b1; ram_waddr = lo_r; ram_wdata = va_r;
      end
      m3qs_pkg::OP_WR_HI: begin
        ram_we = 1'b1; ram_waddr = hi_r; ram_wdata = vm_r;
      end
      m3qs_pkg::OP_WR_MID: begin
        ram_we = 1'b1; ram_waddr = mid; ram_wdata = vh_r;
      end
      m3qs_pkg::OP_P_RD:  ram_raddr = j_r;
      m3qs_pkg::OP_P_CMP: ram_raddr = i_r;
      m3qs_pkg::OP_P_SW1: begin
        ram_we = 1'b1; ram_waddr = j_r; ram_wdata = rdata;
      end
      m3qs_pkg::OP_P_SW2: begin
        ram_we = 1'b1; ram_waddr = i_r; ram_wdata = vh_r;
      end
      m3qs_pkg::OP_F_RD: ram_raddr = i_r;
      m3qs_pkg::OP_F_W1: begin
        ram_we = 1'b1; ram_waddr = hi_r; ram_wdata = rdata;
      end
      m3qs_pkg::OP_F_W2: begin
        ram_we = 1'b1; ram_waddr = i_r; ram_wdata = vm_r;
      end
      m3qs_pkg::OP_I_RDK: ram_raddr = j_r;
      m3qs_pkg::OP_I_RDM: ram_raddr = i_r - 1'b1;
      m3qs_pkg::OP_I_CMP: begin
        ram_we = stat.rd_gt_x; ram_waddr = i_r; ram_wdata = rdata;
      end
      m3qs_pkg::OP_I_WR: begin
        ram_we = 1'b1; ram_waddr = i_r; ram_wdata = va_r;
      end
      default: ;
    endcase
  end

  // Result selection
  always_comb begin
    out_load       = 1'b0;
    out_value_nxt  = '0;
    out_count_nxt  = m3qs_pkg::COUNT_W'(fill_r);
    out_status_nxt = m3qs_pkg::ST_READ_OK;
    case (op)
      m3qs_pkg::OP_IDLE: begin
        if (in_command == m3qs_pkg::CMD_READ) begin
          out_load       = accept && !rd_ok;
          out_status_nxt = m3qs_pkg::ST_RANGE;
        end else begin
          out_load       = accept && is_full;
          out_count_nxt  = m3qs_pkg::COUNT_W'(fill_eff);
          out_status_nxt = m3qs_pkg::ST_FULL;
        end
      end
      m3qs_pkg::OP_RD_OUT: begin
        out_load      = 1'b1;
        out_value_nxt = m3qs_pkg::VALUE_W'(rdata);
      end
      m3qs_pkg::OP_FINISH: begin
        out_load       = 1'b1;
        out_status_nxt = m3qs_pkg::ST_SORT_DONE;
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      sorted_r    <= 1'b0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (op)
        m3qs_pkg::OP_IDLE: begin
          if (do_load) begin
            sorted_r <= 1'b0;
            if (!is_full) begin
              fill_r <= fill_eff + 1'b1;
              if (in_last) begin
                sp_r <= '0;
              end
            end
          end
        end
        m3qs_pkg::OP_POP:    sp_r     <= sp_m1;
        m3qs_pkg::OP_FINISH: sorted_r <= 1'b1;
        m3qs_pkg::OP_DEC: begin
          if (!b_triv && !sp_full) begin
            sp_r <= sp_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r  <= out_value_nxt;
      out_count_r  <= out_count_nxt;
      out_status_r <= out_status_nxt;
    end
    case (op)
      m3qs_pkg::OP_IDLE: begin
        if (do_load && !is_full && in_last) begin
          lo_r <= '0;
          hi_r <= fill_eff[ADDR_W-1:0];
        end
      end
      m3qs_pkg::OP_POP: begin
        lo_r <= pop_ent[2*ADDR_W-1:ADDR_W];
        hi_r <= pop_ent[ADDR_W-1:0];
      end
      m3qs_pkg::OP_RD_MID: va_r <= rdata;
      m3qs_pkg::OP_RD_HI:  vm_r <= rdata;
      m3qs_pkg::OP_CAP_HI: vh_r <= rdata;
      m3qs_pkg::OP_SW_AM: begin
        if (va_r > vm_r) begin
          va_r <= vm_r;
          vm_r <= va_r;
        end
      end
      // with mid on lo, the two value registers track one entry
      m3qs_pkg::OP_SW_AH: begin
        if (va_r > vh_r) begin
          va_r <= vh_r;
          vh_r <= va_r;
          if (alias_m) begin
            vm_r <= vh_r;
          end
        end
      end
      m3qs_pkg::OP_SW_MH: begin
        if (vm_r > vh_r) begin
          vm_r <= vh_r;
          vh_r <= vm_r;
          if (alias_m) begin
            va_r <= vh_r;
          end
        end
      end
      m3qs_pkg::OP_WR_HI: begin
        i_r <= lo_r;
        j_r <= lo_r;
      end
      m3qs_pkg::OP_P_CMP: begin
        vh_r <= rdata;
        if (!stat.rd_lt_pv) begin
          j_r <= j_r + 1'b1;
        end else if (i_r == j_r) begin
          i_r <= i_r + 1'b1;
          j_r <= j_r + 1'b1;
        end
      end
      m3qs_pkg::OP_P_SW2: begin
        i_r <= i_r + 1'b1;
        j_r <= j_r + 1'b1;
      end
      m3qs_pkg::OP_DEC: begin
        if (b_triv || !sp_full) begin
          if (s_empty) begin
            lo_r <= ADDR_W'(1);
            hi_r <= '0;
          end else begin
            lo_r <= s_lo;
            hi_r <= s_hi;
          end
          if (!b_triv) begin
            stk_r[sp_r[SI_W-1:0]] <= {b_lo, b_hi};
          end
        end else begin
          // stack full: finish the small side in place, then go on with the big one
          lo_r  <= b_lo;
          hi_r  <= b_hi;
          ilo_r <= s_lo;
          ihi_r <= s_hi;
          j_r   <= s_lo + 1'b1;
        end
      end
      m3qs_pkg::OP_I_CAPX: begin
        va_r <= rdata;
        i_r  <= j_r;
      end
      m3qs_pkg::OP_I_CMP: begin
        if (stat.rd_gt_x) begin
          i_r <= i_r - 1'b1;
        end
      end
      m3qs_pkg::OP_I_WR: j_r <= j_r + 1'b1;
      default: ;
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_sorted_value  = out_value_r;
  assign out_element_count = out_count_r;
  assign out_status        = out_status_r;

endmodule
